// ===== rtl/spq_pkg.sv =====
// spq_pkg: types and constants shared by the sorted priority queue modules.
// No dependencies; used by spq_ctrl, spq_datapath and sorted_priority_queue_top.
package spq_pkg;

   localparam int KEY_BITS     = 16;
   localparam int GRADE_BITS   = 10;
   localparam int COURSE_BITS  = 6;
   localparam int ELEM_BITS    = 32;
   localparam int OCC_BITS     = 5;
   localparam int STATUS_BITS  = 2;

   localparam logic FUNC_ENQUEUE = 1'b0;
   localparam logic FUNC_DEQUEUE = 1'b1;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_DEQ_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ENQ_FULL  = 2'd2;

   typedef struct packed {
      logic                   func;
      logic [ELEM_BITS-1:0]   element;
      logic [GRADE_BITS-1:0]  average_hundredths;
      logic [COURSE_BITS-1:0] course_count;
   } req_type;

   typedef struct packed {
      logic                   head_valid;
      logic [ELEM_BITS-1:0]   head_element;
      logic [KEY_BITS-1:0]    head_key;
      logic [COURSE_BITS-1:0] head_courses;
      logic [OCC_BITS-1:0]    occupancy;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } cmd_type;

endpackage

// ===== rtl/spq_ctrl.sv =====
// spq_ctrl: sequencer for the sorted priority queue (capture, execute, respond).
// Depends on spq_pkg for the command struct.
module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   output logic             rsp_strobe,
   output spq_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign busy        = (state_ff == ST_EXEC);
   assign rsp_strobe  = (state_ff == ST_RESP);
   assign cmd.capture = start && !busy;
   assign cmd.execute = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = cmd.capture ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_capture_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.execute)
      else $error("captured transaction not executed");

   a_exec_to_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> rsp_strobe)
      else $error("executed transaction gave no response");

   a_no_double_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> !cmd.execute)
      else $error("execute held for two cycles");

endmodule

// ===== rtl/spq_datapath.sv =====
// spq_datapath: sorted register cells, key multiplier, count and status.
// Depends on spq_pkg; driven by spq_ctrl commands.
module spq_datapath #(
   parameter int DEPTH        = 16,
   parameter int ELEMENT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  spq_pkg::cmd_type cmd,
   input  spq_pkg::req_type req,
   output spq_pkg::rsp_type rsp
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int STORE_W = (ELEMENT_BITS < spq_pkg::ELEM_BITS) ? ELEMENT_BITS
                                                               : spq_pkg::ELEM_BITS;

   logic                            func_ff;
   logic [STORE_W-1:0]              elem_ff;
   logic [spq_pkg::KEY_BITS-1:0]    key_ff;
   logic [spq_pkg::COURSE_BITS-1:0] courses_ff;

   logic [STORE_W-1:0]              cell_elem_ff [DEPTH];
   logic [STORE_W-1:0]              cell_elem_in [DEPTH];
   logic [spq_pkg::KEY_BITS-1:0]    cell_key_ff  [DEPTH];
   logic [spq_pkg::KEY_BITS-1:0]    cell_key_in  [DEPTH];
   logic [spq_pkg::COURSE_BITS-1:0] cell_crs_ff  [DEPTH];
   logic [spq_pkg::COURSE_BITS-1:0] cell_crs_in  [DEPTH];

   logic [CNT_W-1:0]                count_ff, count_in;
   logic [spq_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [DEPTH-1:0]                after_new;

   // transaction capture, key product registered before the insert
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff    <= req.func;
         elem_ff    <= req.element[STORE_W-1:0];
         key_ff     <= spq_pkg::KEY_BITS'(req.average_hundredths) *
                       spq_pkg::KEY_BITS'(req.course_count);
         courses_ff <= req.course_count;
      end
   end

   // thermometer: cells that sit after the new entry
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         after_new[i] = (CNT_W'(i) >= count_ff) || (key_ff < cell_key_ff[i]);
      end
   end

   always_comb begin
      cell_elem_in = cell_elem_ff;
      cell_key_in  = cell_key_ff;
      cell_crs_in  = cell_crs_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      if (cmd.execute) begin
         if (func_ff == spq_pkg::FUNC_ENQUEUE) begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status_in = spq_pkg::STATUS_ENQ_FULL;
            end else begin
               status_in = spq_pkg::STATUS_OK;
               count_in  = count_ff + CNT_W'(1);
               for (int i = 0; i < DEPTH; i++) begin
                  if (after_new[i]) begin
                     if (i == 0 || !after_new[(i == 0) ? 0 : i - 1]) begin
                        cell_elem_in[i] = elem_ff;
                        cell_key_in[i]  = key_ff;
                        cell_crs_in[i]  = courses_ff;
                     end else begin
                        cell_elem_in[i] = cell_elem_ff[(i == 0) ? 0 : i - 1];
                        cell_key_in[i]  = cell_key_ff[(i == 0) ? 0 : i - 1];
                        cell_crs_in[i]  = cell_crs_ff[(i == 0) ? 0 : i - 1];
                     end
                  end
               end
            end
         end else begin
            if (count_ff == '0) begin
               status_in = spq_pkg::STATUS_DEQ_EMPTY;
            end else begin
               status_in = spq_pkg::STATUS_OK;
               count_in  = count_ff - CNT_W'(1);
               for (int i = 0; i < DEPTH - 1; i++) begin
                  cell_elem_in[i] = cell_elem_ff[i + 1];
                  cell_key_in[i]  = cell_key_ff[i + 1];
                  cell_crs_in[i]  = cell_crs_ff[i + 1];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_elem_ff <= cell_elem_in;
      cell_key_ff  <= cell_key_in;
      cell_crs_ff  <= cell_crs_in;
      status_ff    <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      rsp.head_valid   = (count_ff != '0);
      rsp.head_element = rsp.head_valid ? spq_pkg::ELEM_BITS'(cell_elem_ff[0]) : '0;
      rsp.head_key     = rsp.head_valid ? cell_key_ff[0] : '0;
      rsp.head_courses = rsp.head_valid ? cell_crs_ff[0] : '0;
      rsp.occupancy    = spq_pkg::OCC_BITS'(count_ff);
      rsp.status       = status_ff;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.execute) |-> $stable(count_ff))
      else $error("entry count moved without execute");

   a_empty_deq: assert property (@(posedge clock) disable iff (reset)
      cmd.execute && func_ff == spq_pkg::FUNC_DEQUEUE && count_ff == '0
      |=> status_ff == spq_pkg::STATUS_DEQ_EMPTY && count_ff == '0)
      else $error("dequeue on empty not flagged");

endmodule

// ===== rtl/sorted_priority_queue_top.sv =====
// sorted_priority_queue_top: min-first sorted priority queue, FIFO among equal keys.
// Sequence: the accepting edge registers the request (EXEC), the cell update is registered on leaving EXEC, then RESP.
// busy covers the cell-update state EXEC; a new transaction can be accepted in RESP.
// Reset: synchronous; occupancy cleared, cell contents left as they are.
// The receiver cannot stall; rsp_strobe is high for exactly one cycle.
module sorted_priority_queue_top #(
   parameter int DEPTH        = 16,
   parameter int ELEMENT_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  spq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output spq_pkg::rsp_type rsp_data
);

   spq_pkg::cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd)
   );

   spq_datapath #(
      .DEPTH        (DEPTH),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .req   (req_data),
      .rsp   (rsp_data)
   );

endmodule
